[hdl/ost_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ost_pkg
// Shared types and constants for the owner set table.
// ----------------------------------------------------------------------------
package ost_pkg;

    localparam int MAX_ENTRIES_DEF = 8;
    localparam int ID_W            = 32;
    localparam int REQ_W           = 2;
    localparam int TOTAL_W         = 4;

    typedef logic [ID_W-1:0] t_id;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_NOP    = 2'd3
    } t_req;

    // per-beat update strobes broadcast to every cell
    typedef struct packed {
        logic do_add;
        logic do_del;
    } t_cell_ctl;

endpackage

[hdl/ost_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ost_cell
// One slot of the id list: compares, passes the match chain on, takes
// the new id on an add at the tail and its upper neighbor's id on a delete.
// ----------------------------------------------------------------------------
module ost_cell import ost_pkg::*; #(
    parameter int CNT_W = 4,
    parameter int IDX   = 0
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  t_id              i_user_id,
    input  logic [CNT_W-1:0] i_count,
    input  logic             i_hit_prev,
    input  t_id              i_next_id,
    output logic             o_hit_upto,
    output t_id              o_id
);

    t_id  r_id;
    logic slot_valid;
    logic slot_tail;
    logic hit;

    assign slot_valid = CNT_W'(IDX) < i_count;
    assign slot_tail  = CNT_W'(IDX) == i_count;
    assign hit        = slot_valid && (r_id == i_user_id);
    assign o_hit_upto = i_hit_prev | hit;
    assign o_id       = r_id;

    always_ff @(posedge i_clk) begin
        if (i_ctl.do_add && slot_tail) begin
            r_id <= i_user_id;
        end else if (i_ctl.do_del && o_hit_upto) begin
            r_id <= i_next_id;
        end
    end

endmodule

[hdl/owner_set_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owner_set_table_top
// Bounded duplicate-free set of user ids kept as a packed row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel i_in_valid / o_in_ready carries i_req_type and
//   i_user_id (add, query, delete, or no-op). Result channel
//   o_out_valid / i_out_ready carries the count after the request, the
//   prior-membership flag, the query answer and the full-drop flag.
//   Every request yields exactly one result beat.
//   The result is registered and shows in the cycle after the request
//   beat. One request per cycle while no stalled result is held; all
//   cells compare in parallel and the delete shift happens in the same
//   cycle; the match chain over all MAX_ENTRIES cells is combinational.
//   A new request is taken while a result waits, as long as the
//   receiver takes it in that same cycle; if the receiver stalls, the
//   result is held and o_in_ready drops until it is taken.
//   Reset empties the list (count zero) and clears the result valid.
//   Stored ids are not cleared; only slots below the count are compared.
// ----------------------------------------------------------------------------
module owner_set_table_top import ost_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [ID_W-1:0]    i_user_id,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [TOTAL_W-1:0] o_entry_total,
    output logic               o_matched,
    output logic               o_allowed,
    output logic               o_dropped_full
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic [TOTAL_W-1:0] r_total;
    logic             r_matched;
    logic             r_allowed;
    logic             r_dropped;

    logic             accept;
    logic             any_hit;
    logic             full;
    logic             allowed;
    logic             dropped;
    t_req             req;
    t_cell_ctl        ctl;
    logic [CNT_W+TOTAL_W-1:0] total_ext;

    logic             hit_chain [MAX_ENTRIES+1];
    t_id              cell_ids  [MAX_ENTRIES];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign req        = t_req'(i_req_type);
    assign full       = r_count == CNT_W'(MAX_ENTRIES);
    assign hit_chain[0] = 1'b0;
    assign any_hit    = hit_chain[MAX_ENTRIES];

    always_comb begin
        ctl     = '0;
        n_count = r_count;
        allowed = 1'b0;
        dropped = 1'b0;
        unique case (req)
            REQ_ADD: begin
                if (!any_hit && !full) begin
                    ctl.do_add = accept;
                    n_count    = r_count + 1'b1;
                end
                dropped = !any_hit && full;
            end
            REQ_QUERY: begin
                allowed = any_hit || (r_count == '0);
            end
            REQ_DELETE: begin
                if (any_hit) begin
                    ctl.do_del = accept;
                    n_count    = r_count - 1'b1;
                end
            end
            REQ_NOP: begin
            end
            default: begin
            end
        endcase
    end

    assign total_ext = {{TOTAL_W{1'b0}}, n_count};

    genvar k;
    generate
        for (k = 0; k < MAX_ENTRIES; k++) begin : g_cell
            t_id next_id;
            if (k < MAX_ENTRIES - 1) begin : g_mid
                assign next_id = cell_ids[k+1];
            end else begin : g_last
                assign next_id = cell_ids[k];
            end
            ost_cell #(
                .CNT_W (CNT_W),
                .IDX   (k)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_user_id  (i_user_id),
                .i_count    (r_count),
                .i_hit_prev (hit_chain[k]),
                .i_next_id  (next_id),
                .o_hit_upto (hit_chain[k+1]),
                .o_id       (cell_ids[k])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_total   <= total_ext[TOTAL_W-1:0];
            r_matched <= any_hit;
            r_allowed <= allowed;
            r_dropped <= dropped;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_entry_total  = r_total;
    assign o_matched      = r_matched;
    assign o_allowed      = r_allowed;
    assign o_dropped_full = r_dropped;

endmodule
